[hw/rtl/h2r_pkg.sv]
package h2r_pkg;

    // Hue scale: 64 steps per degree
    localparam int unsigned FULL_TURN   = 23040;
    localparam int unsigned SECTOR_SPAN = 3840;
    localparam int unsigned UNIT_SCALE  = 255;
    localparam int unsigned FRAC_DENOM  = UNIT_SCALE * SECTOR_SPAN;

    // Channel quotient by FRAC_DENOM: drop 8 bits, then divide by DIV_LOW
    localparam int unsigned DIV_SHIFT   = 8;
    localparam int unsigned DIV_LOW     = FRAC_DENOM >> DIV_SHIFT;
    localparam int unsigned RECIP_SHIFT = 28;
    localparam int unsigned RECIP_MUL   = (1 << RECIP_SHIFT) / DIV_LOW;

    localparam int unsigned HUE_W  = 16;
    localparam int unsigned CH_W   = 8;
    localparam int unsigned REM_W  = 12;
    localparam int unsigned SPR_W  = 20;
    localparam int unsigned PROD_W = 28;

    // Sixty-degree sectors, named by the colour at their start
    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } sector_t;

endpackage

[hw/rtl/h2r_hsv_if.sv]
interface h2r_hsv_if;
    logic                                valid;
    logic                                ready;
    logic [h2r_pkg::HUE_W-1:0]           hue;
    logic [h2r_pkg::CH_W-1:0]            sat;
    logic [h2r_pkg::CH_W-1:0]            val;

    modport source (output valid, output hue, output sat, output val, input ready);
    modport sink   (input valid, input hue, input sat, input val, output ready);
endinterface

[hw/rtl/h2r_rgb_if.sv]
interface h2r_rgb_if;
    logic                                valid;
    logic                                ready;
    logic [h2r_pkg::CH_W-1:0]            red;
    logic [h2r_pkg::CH_W-1:0]            green;
    logic [h2r_pkg::CH_W-1:0]            blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[hw/rtl/h2r_frac_div.sv]
// Floor of a channel product by 255*3840, over one register stage.
// Estimate by reciprocal multiply in front of the register, correct behind it.
module h2r_frac_div (
    input  logic                             clk,
    input  logic                             en,
    input  logic [h2r_pkg::PROD_W-1:0]       prod,
    output logic [h2r_pkg::CH_W-1:0]         quo
);

    localparam int unsigned Y_W   = h2r_pkg::PROD_W - h2r_pkg::DIV_SHIFT;
    localparam int unsigned MUL_W = Y_W + 17;

    logic [Y_W-1:0]             y;
    logic [MUL_W-1:0]           mul;
    logic [h2r_pkg::CH_W-1:0]   est;
    logic [Y_W-1:0]             y_reg;
    logic [h2r_pkg::CH_W-1:0]   est_reg;
    logic [Y_W-1:0]             rem;
    logic [h2r_pkg::CH_W:0]     quo_wide;

    // Estimate: at most one below the true quotient
    assign y   = prod[h2r_pkg::PROD_W-1:h2r_pkg::DIV_SHIFT];
    assign mul = MUL_W'(y) * MUL_W'(h2r_pkg::RECIP_MUL);
    assign est = mul[h2r_pkg::RECIP_SHIFT+h2r_pkg::CH_W-1:h2r_pkg::RECIP_SHIFT];

    // Hold the estimate while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg   <= y;
            est_reg <= est;
        end
    end

    // Correct by one where the remainder reaches the divisor
    assign rem      = y_reg - Y_W'(est_reg) * Y_W'(h2r_pkg::DIV_LOW);
    assign quo_wide = (rem >= Y_W'(h2r_pkg::DIV_LOW)) ? ({1'b0, est_reg} + 9'd1)
                                                      : {1'b0, est_reg};
    assign quo      = quo_wide[h2r_pkg::CH_W-1:0];

endmodule

[hw/rtl/hsv_to_rgb_pixel_unit.sv]
// Channel   Dir   Payload                         Handshake
// pix_hsv   in    hue[16] sat[8] val[8]           valid/ready
// pix_rgb   out   red[8] green[8] blue[8]         valid/ready
//
// Five register stages: sector split, products, p and channel numerators,
// reciprocal estimate, correction and sector select into the output register.
// One item per clock sustained while the output is ready.
// Reset clears the stage valid bits only; payload registers are not reset.
// Each stage advances when empty or when the next one advances, so bubbles
// close up behind a stalled output and no item is lost or repeated.
module hsv_to_rgb_pixel_unit (
    input  logic          clk,
    input  logic          rst_n,
    h2r_hsv_if.sink       pix_hsv,
    h2r_rgb_if.source     pix_rgb
);

    localparam int unsigned HW = h2r_pkg::HUE_W;
    localparam int unsigned CW = h2r_pkg::CH_W;
    localparam int unsigned RW = h2r_pkg::REM_W;
    localparam int unsigned SW = h2r_pkg::SPR_W;
    localparam int unsigned PW = h2r_pkg::PROD_W;

    // Stage enables and valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5 = !v5_reg || pix_rgb.ready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign pix_hsv.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pix_hsv.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: map a hue at or above a full turn to zero, find sector and position within it
    logic [HW-1:0]        hue_w;
    h2r_pkg::sector_t     sector_next;
    logic [HW-1:0]        base;
    logic [HW-1:0]        rem_w;
    h2r_pkg::sector_t     sector1_reg;
    logic [RW-1:0]        rem1_reg;
    logic [CW-1:0]        sat1_reg, val1_reg;

    assign hue_w = (pix_hsv.hue >= HW'(h2r_pkg::FULL_TURN)) ? '0 : pix_hsv.hue;

    always_comb
    begin
        if (hue_w >= HW'(5 * h2r_pkg::SECTOR_SPAN))
        begin
            sector_next = h2r_pkg::SEC_MAGENTA;
            base        = HW'(5 * h2r_pkg::SECTOR_SPAN);
        end
        else if (hue_w >= HW'(4 * h2r_pkg::SECTOR_SPAN))
        begin
            sector_next = h2r_pkg::SEC_BLUE;
            base        = HW'(4 * h2r_pkg::SECTOR_SPAN);
        end
        else if (hue_w >= HW'(3 * h2r_pkg::SECTOR_SPAN))
        begin
            sector_next = h2r_pkg::SEC_CYAN;
            base        = HW'(3 * h2r_pkg::SECTOR_SPAN);
        end
        else if (hue_w >= HW'(2 * h2r_pkg::SECTOR_SPAN))
        begin
            sector_next = h2r_pkg::SEC_GREEN;
            base        = HW'(2 * h2r_pkg::SECTOR_SPAN);
        end
        else if (hue_w >= HW'(h2r_pkg::SECTOR_SPAN))
        begin
            sector_next = h2r_pkg::SEC_YELLOW;
            base        = HW'(h2r_pkg::SECTOR_SPAN);
        end
        else
        begin
            sector_next = h2r_pkg::SEC_RED;
            base        = '0;
        end
    end

    assign rem_w = hue_w - base;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            sector1_reg <= sector_next;
            rem1_reg    <= rem_w[RW-1:0];
            sat1_reg    <= pix_hsv.sat;
            val1_reg    <= pix_hsv.val;
        end
    end

    // Stage 2: saturation products
    h2r_pkg::sector_t     sector2_reg;
    logic [CW-1:0]        val2_reg;
    logic [SW-1:0]        srem2_reg, scomp2_reg;
    logic [2*CW-1:0]      pnum2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            sector2_reg <= sector1_reg;
            val2_reg    <= val1_reg;
            srem2_reg   <= SW'(sat1_reg) * SW'(rem1_reg);
            scomp2_reg  <= SW'(sat1_reg)
                           * (SW'(h2r_pkg::SECTOR_SPAN) - SW'(rem1_reg));
            pnum2_reg   <= (2*CW)'(val1_reg)
                           * ((2*CW)'(h2r_pkg::UNIT_SCALE) - (2*CW)'(sat1_reg));
        end
    end

    // Stage 3: p by 255 through reciprocal, numerators of q and t
    logic [24:0]          p_mul;
    logic [CW-1:0]        p_est;
    logic [2*CW-1:0]      p_rem;
    logic [CW:0]          p_wide;
    h2r_pkg::sector_t     sector3_reg;
    logic [CW-1:0]        val3_reg, p3_reg;
    logic [PW-1:0]        qprod3_reg, tprod3_reg;

    assign p_mul  = 25'(pnum2_reg) + (25'(pnum2_reg) << CW);
    assign p_est  = p_mul[2*CW+CW-1:2*CW];
    assign p_rem  = pnum2_reg - (2*CW)'(p_est) * (2*CW)'(h2r_pkg::UNIT_SCALE);
    assign p_wide = (p_rem >= (2*CW)'(h2r_pkg::UNIT_SCALE)) ? ({1'b0, p_est} + 9'd1)
                                                            : {1'b0, p_est};

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            sector3_reg <= sector2_reg;
            val3_reg    <= val2_reg;
            p3_reg      <= p_wide[CW-1:0];
            qprod3_reg  <= PW'(val2_reg) * (PW'(h2r_pkg::FRAC_DENOM) - PW'(srem2_reg));
            tprod3_reg  <= PW'(val2_reg) * (PW'(h2r_pkg::FRAC_DENOM) - PW'(scomp2_reg));
        end
    end

    // Stage 4: divide q and t numerators, carry p and v alongside
    h2r_pkg::sector_t     sector4_reg;
    logic [CW-1:0]        val4_reg, p4_reg;
    logic [CW-1:0]        q_quo, t_quo;

    h2r_frac_div u_div_q (
        .clk  (clk),
        .en   (en4),
        .prod (qprod3_reg),
        .quo  (q_quo)
    );

    h2r_frac_div u_div_t (
        .clk  (clk),
        .en   (en4),
        .prod (tprod3_reg),
        .quo  (t_quo)
    );

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            sector4_reg <= sector3_reg;
            val4_reg    <= val3_reg;
            p4_reg      <= p3_reg;
        end
    end

    // Stage 5: route v, p, q, t by sector into the output register
    logic [CW-1:0]        red_next, green_next, blue_next;
    logic [CW-1:0]        red_reg, green_reg, blue_reg;

    always_comb
    begin
        case (sector4_reg)
            h2r_pkg::SEC_RED:
            begin
                red_next = val4_reg; green_next = t_quo;    blue_next = p4_reg;
            end
            h2r_pkg::SEC_YELLOW:
            begin
                red_next = q_quo;    green_next = val4_reg; blue_next = p4_reg;
            end
            h2r_pkg::SEC_GREEN:
            begin
                red_next = p4_reg;   green_next = val4_reg; blue_next = t_quo;
            end
            h2r_pkg::SEC_CYAN:
            begin
                red_next = p4_reg;   green_next = q_quo;    blue_next = val4_reg;
            end
            h2r_pkg::SEC_BLUE:
            begin
                red_next = t_quo;    green_next = p4_reg;   blue_next = val4_reg;
            end
            default:
            begin
                red_next = val4_reg; green_next = p4_reg;   blue_next = q_quo;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign pix_rgb.valid = v5_reg;
    assign pix_rgb.red   = red_reg;
    assign pix_rgb.green = green_reg;
    assign pix_rgb.blue  = blue_reg;

    // Accepted item lands in stage 1
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_hsv.valid && pix_hsv.ready) |=> v1_reg)
        else $error("accepted item missing from stage 1");

    // Position within a sector stays below one sector span
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (rem1_reg < RW'(h2r_pkg::SECTOR_SPAN)))
        else $error("sector remainder out of range");

    // Corrected quotients never exceed value
    a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> ((q_quo <= val4_reg) && (t_quo <= val4_reg) && (p4_reg <= val4_reg)))
        else $error("channel quotient above value");

    // A held result keeps the stages behind it from overwriting it
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && !pix_rgb.ready) |-> !en4 || !v4_reg)
        else $error("stage 4 advanced into a stalled output");

endmodule
